>>> design/pcx_row_rle_encoder_assert.svh
// Assertion macros used by the encoder's checker.
`ifndef PCX_ROW_RLE_ENCODER_ASSERT_SVH
`define PCX_ROW_RLE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PCXRLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcx rle encoder: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PCXRLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcx rle encoder: next-cycle check failed");

`endif

>>> design/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam int unsigned MAX_WIDTH   = 65534;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned CAP_W       = 19;
  localparam int unsigned RUN_W       = 6;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = CAP_W;
  localparam int unsigned NUM_PLANES  = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [RUN_W-1:0]   RUN_MAX         = 6'd63;
  localparam logic [7:0]         COUNT_MARK      = 8'hc0;
  localparam logic [7:0]         ROUND_BIAS      = 8'd127;
  localparam logic [7:0]         FULL_SCALE      = 8'd255;
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 16'd1;
  localparam logic [CAP_W-1:0]   CAP_RESET       = 19'd393216;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_CAPACITY = 2'd1;

  typedef struct packed {
    logic [7:0] colour_value;
    logic [7:0] alpha_value;
  } pixel_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       row_done;
    logic       overflow;
  } result_t;

  // One composited sample with its place in the row, as queued to the coder
  typedef struct packed {
    logic [7:0] value;
    logic       line_end;
    logic       pad;
    logic       row_end;
  } sample_t;

  typedef enum logic [1:0] {
    ST_ADD,
    ST_PAD,
    ST_FLUSH,
    ST_DATA
  } back_state_t;

  // Divide by 255 for values up to 65279: (y + (y >> 8) + 1) >> 8
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] s;
    s = {1'b0, y} + {9'b0, y[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> design/pcx_row_rle_encoder.sv
// PCX-style run-length encoder for one RGB row, samples in plane-major order
// (all R samples, then G, then B), each with its alpha. A single-stage front end
// composites every sample over white with rounding and tags line and row
// ends; a four-deep queue decouples it from the coder, which keeps the open
// run and sends one byte per cycle through its output register while
// code_stall is low. A sample that extends a run sends no byte; a sample
// that closes a run sends its value byte, or a count byte and then the value
// byte for a two-byte run. A line-end sample is added to the run, a zero pad
// follows when the width is odd, and a final flush sends the open run. The
// sustained rate is set by the coder's one-byte-per-cycle output. An overflow
// gives one beat with overflow and row_done set; the rest of the row is
// consumed without output. Writes to row_width and output_capacity are taken
// at any time with cfg_ready high.
module pcx_row_rle_encoder
  import pcxrle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  output logic                   code_valid,
  input  logic                   code_stall,
  output result_t                code,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WIDTH_W-1:0] row_width;
  logic [CAP_W-1:0]   output_capacity;
  logic               push_valid;
  logic               push_full;
  sample_t            push_data;
  logic               pop;
  logic               head_valid;
  sample_t            head;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= ROW_WIDTH_RESET;
      output_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:       row_width       <= cfg_data[WIDTH_W-1:0];
        REG_OUTPUT_CAPACITY: output_capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcxrle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .row_width  (row_width),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  pcxrle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_full (push_full),
    .push_data (push_data),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  pcxrle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .output_capacity(output_capacity),
    .code_valid     (code_valid),
    .code_stall     (code_stall),
    .code           (code)
  );

endmodule

>>> design/pcxrle_front.sv
module pcxrle_front
  import pcxrle_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  pixel_t              pixel,
  input  logic [WIDTH_W-1:0]  row_width,
  output logic                push_valid,
  input  logic                push_full,
  output sample_t             push_data
);

  logic [WIDTH_W-1:0] column;
  logic [1:0]         plane;
  logic               s1_valid;
  logic [15:0]        s1_prod;
  logic [7:0]         s1_white;
  logic               s1_line_end;
  logic               s1_pad;
  logic               s1_row_end;

  logic [WIDTH_W-1:0] width_eff;
  logic [WIDTH_W-1:0] col_inc;
  logic               line_end;
  logic               accept;
  logic               push;

  // Clamp the width into its legal range
  always_comb begin
    if (row_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (row_width > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = row_width;
    end
  end

  assign col_inc     = column + WIDTH_W'(1);
  assign line_end    = (col_inc >= width_eff);
  assign push        = s1_valid && !push_full;
  assign pixel_stall = s1_valid && push_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push_valid  = s1_valid;

  // Track column and plane of the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      plane    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (line_end) begin
          column <= '0;
          plane  <= (plane == 2'(NUM_PLANES - 1)) ? 2'd0 : plane + 2'd1;
        end else begin
          column <= col_inc;
        end
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Register the product and the white share of the blend
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod     <= {8'b0, pixel.colour_value} * {8'b0, pixel.alpha_value}
                     + {8'b0, ROUND_BIAS};
      s1_white    <= FULL_SCALE - pixel.alpha_value;
      s1_line_end <= line_end;
      s1_pad      <= line_end && width_eff[0];
      s1_row_end  <= line_end && (plane == 2'(NUM_PLANES - 1));
    end
  end

  // Finish the composite: white share plus rounded colour share
  always_comb begin
    push_data.value    = s1_white + div255(s1_prod);
    push_data.line_end = s1_line_end;
    push_data.pad      = s1_pad;
    push_data.row_end  = s1_row_end;
  end

endmodule

>>> design/pcxrle_fifo.sv
module pcxrle_fifo
  import pcxrle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_full,
  input  sample_t push_data,
  input  logic    pop,
  output logic    head_valid,
  output sample_t head
);

  sample_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   push;

  assign push_full  = (fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign push       = push_valid && !push_full;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/pcxrle_back.sv
module pcxrle_back
  import pcxrle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  sample_t          head,
  output logic             pop,
  input  logic [CAP_W-1:0] output_capacity,
  output logic             code_valid,
  input  logic             code_stall,
  output result_t          code
);

  back_state_t       state;
  back_state_t       state_next;
  back_state_t       pend_ret;
  logic [7:0]        run_value;
  logic [RUN_W-1:0]  run_length;
  logic [CAP_W-1:0]  bytes_sent;
  logic              overflowed;
  result_t           pend_beat;
  logic              pend_pop;

  logic              out_free;
  logic              is_add;
  logic [7:0]        op_value;
  logic              joins;
  logic              do_flush;
  logic              need2;
  logic [CAP_W:0]    total;
  logic              fits;
  logic              done_flag;
  logic              go;
  logic              split;
  back_state_t       after_state;
  logic              after_pop;
  logic              load;
  result_t           load_beat;
  result_t           first_beat;
  result_t           second_beat;

  assign out_free = !code_valid || !code_stall;

  // Evaluate the current step against the open run
  always_comb begin
    is_add    = (state == ST_ADD) || (state == ST_PAD);
    op_value  = (state == ST_PAD) ? 8'd0 : head.value;
    joins     = (run_length != '0) && (op_value == run_value) && (run_length < RUN_MAX);
    do_flush  = (state != ST_DATA) && !overflowed && (run_length != '0)
                && (!is_add || !joins);
    need2     = (run_length > RUN_W'(1)) || (run_value >= COUNT_MARK);
    total     = {1'b0, bytes_sent} + (need2 ? (CAP_W + 1)'(2) : (CAP_W + 1)'(1));
    fits      = (total <= {1'b0, output_capacity});
    done_flag = (state == ST_FLUSH) && head.row_end;
    split     = do_flush && fits && need2;

    first_beat  = {run_value, done_flag, 1'b0};
    second_beat = {run_value, done_flag, 1'b0};
    if (!fits) begin
      first_beat = {8'd0, 1'b1, 1'b1};
    end else if (need2) begin
      first_beat = {COUNT_MARK | {2'b0, run_length}, 1'b0, 1'b0};
    end

    if (state == ST_DATA) begin
      go = out_free;
    end else begin
      go = head_valid && (!do_flush || out_free);
    end
  end

  // Next state
  always_comb begin
    after_state = ST_ADD;
    after_pop   = 1'b0;
    case (state)
      ST_ADD: begin
        if (head.line_end) begin
          after_state = head.pad ? ST_PAD : ST_FLUSH;
        end else begin
          after_pop = 1'b1;
        end
      end
      ST_PAD: begin
        after_state = ST_FLUSH;
      end
      ST_FLUSH: begin
        after_pop = 1'b1;
      end
      ST_DATA: begin
        after_state = pend_ret;
        after_pop   = pend_pop;
      end
      default: begin
        after_state = ST_ADD;
      end
    endcase

    state_next = state;
    if (go) begin
      state_next = split ? ST_DATA : after_state;
    end
  end

  // Outputs of the step: pop and output load
  always_comb begin
    pop       = go && !split && after_pop;
    load      = go && ((state == ST_DATA) || do_flush);
    load_beat = (state == ST_DATA) ? pend_beat : first_beat;
  end

  // Run state, byte budget and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ADD;
      run_value  <= '0;
      run_length <= '0;
      bytes_sent <= '0;
      overflowed <= 1'b0;
    end else begin
      state <= state_next;
      if (go && (state != ST_DATA)) begin
        if (do_flush) begin
          if (fits) begin
            bytes_sent <= total[CAP_W-1:0];
          end else begin
            overflowed <= 1'b1;
          end
        end
        if (is_add && !overflowed) begin
          if (joins) begin
            run_length <= run_length + RUN_W'(1);
          end else begin
            run_value  <= op_value;
            run_length <= RUN_W'(1);
          end
        end
        if (state == ST_FLUSH) begin
          run_length <= '0;
          if (head.row_end) begin
            bytes_sent <= '0;
            overflowed <= 1'b0;
            run_value  <= '0;
          end
        end
      end
    end
  end

  // Hold the value byte that follows a count byte
  always_ff @(posedge clk) begin
    if (go && split) begin
      pend_beat <= second_beat;
      pend_ret  <= after_state;
      pend_pop  <= after_pop;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (load) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code <= load_beat;
    end
  end

endmodule

>>> design/pcxrle_checker.sv
`include "pcx_row_rle_encoder_assert.svh"

module pcxrle_checker
  import pcxrle_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    code_valid,
  input logic    code_stall,
  input result_t code
);

  logic code_beat;
  logic count_shaped;
  logic expect_data;

  assign code_beat    = code_valid && !code_stall;
  assign count_shaped = (code.coded_byte[7:6] == 2'b11) && !code.overflow;

  // Track whether the next output beat must be the value after a count byte
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_data <= 1'b0;
    end else if (code_beat) begin
      expect_data <= !expect_data && count_shaped;
    end
  end

  // Hold a stalled output beat
  `PCXRLE_ASSERT_NEXT(a_code_hold, code_valid && code_stall, code_valid && $stable(code))

  // An overflow beat ends the row and carries a zero byte
  `PCXRLE_ASSERT_IMP(a_overflow_shape, code_valid && code.overflow,
                     code.row_done && (code.coded_byte == 8'd0))

  // A count byte is never split from its value by an overflow
  `PCXRLE_ASSERT_IMP(a_count_then_data, code_valid && expect_data, !code.overflow)

  // A count byte never ends the row
  `PCXRLE_ASSERT_IMP(a_count_not_last, code_valid && !expect_data && count_shaped,
                     !code.row_done)

endmodule

bind pcx_row_rle_encoder pcxrle_checker u_pcxrle_checker (.*);
